>>> sv/psm_pkg.sv
package psm_pkg;

   // Field widths of the request and response channels.
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned ADDR_W  = 8;
   localparam int unsigned CODE_W  = 8;
   localparam int unsigned COUNT_W = 30;
   localparam int unsigned TIME_W  = 24;
   localparam int unsigned GRACE_W = 8;
   localparam int unsigned REPLY_W = 3;

   // Configuration port.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 30;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALL_GRACE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRAP_LIMIT     = 2'd2;

   localparam logic [ADDR_W-1:0]  DEVICE_ADDRESS_RESET = 8'd1;
   localparam logic [GRACE_W-1:0] STALL_GRACE_RESET    = 8'd10;
   localparam logic [COUNT_W-1:0] WRAP_LIMIT_RESET     = 30'd1000000000;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // Operations handed from the classifier to the execution side.
   typedef enum logic [3:0] {
      OP_PULSE,
      OP_TICK,
      OP_EXTEND,
      OP_RETRACT,
      OP_ZERO,
      OP_READ,
      OP_MEASURE_ADVANCE,
      OP_MEASURE_RETRACT,
      OP_RESET,
      OP_QUERY
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } op_req_type;

   // Settings the execution side needs.
   typedef struct packed {
      logic [GRACE_W-1:0] grace_ticks;
      logic [COUNT_W-1:0] wrap_limit;
   } back_cfg_type;

endpackage

>>> sv/psm_front.sv
module psm_front import psm_pkg::*; (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [ADDR_W-1:0] req_address_byte,
   input  logic [CODE_W-1:0] req_command_code,
   input  logic [ADDR_W-1:0] device_address,
   input  logic              queue_full,
   output op_req_type        push
);

   localparam logic [KIND_W-1:0] KIND_PULSE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMMAND = 2'd2;

   localparam logic [CODE_W-1:0] CMD_EXTEND          = 8'd1;
   localparam logic [CODE_W-1:0] CMD_RETRACT         = 8'd2;
   localparam logic [CODE_W-1:0] CMD_ZERO            = 8'd3;
   localparam logic [CODE_W-1:0] CMD_READ            = 8'd4;
   localparam logic [CODE_W-1:0] CMD_MEASURE_ADVANCE = 8'd5;
   localparam logic [CODE_W-1:0] CMD_MEASURE_RETRACT = 8'd6;
   localparam logic [CODE_W-1:0] CMD_RESET           = 8'd7;

   logic   keep;
   op_type op;

   assign req_stall = queue_full;

   // Commands for another address and unused kinds are dropped here.
   always_comb begin
      keep = 1'b0;
      op   = OP_QUERY;
      case (req_kind)
         KIND_PULSE: begin
            keep = 1'b1;
            op   = OP_PULSE;
         end
         KIND_TICK: begin
            keep = 1'b1;
            op   = OP_TICK;
         end
         KIND_COMMAND: begin
            keep = (req_address_byte == device_address);
            case (req_command_code)
               CMD_EXTEND:          op = OP_EXTEND;
               CMD_RETRACT:         op = OP_RETRACT;
               CMD_ZERO:            op = OP_ZERO;
               CMD_READ:            op = OP_READ;
               CMD_MEASURE_ADVANCE: op = OP_MEASURE_ADVANCE;
               CMD_MEASURE_RETRACT: op = OP_MEASURE_RETRACT;
               CMD_RESET:           op = OP_RESET;
               default:             op = OP_QUERY;
            endcase
         end
         default: begin
            keep = 1'b0;
            op   = OP_QUERY;
         end
      endcase
   end

   assign push.valid = req_valid && !queue_full && keep;
   assign push.op    = op;

endmodule

>>> sv/psm_queue.sv
module psm_queue import psm_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  op_req_type push,
   output logic       full,
   output op_req_type head,
   input  logic       pop
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   op_type           slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots_ff[wr_ptr_ff] <= push.op;
      end
   end

   assign full       = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.op    = slots_ff[rd_ptr_ff];

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue fill count above its depth");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

endmodule

>>> sv/psm_back.sv
module psm_back import psm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  op_req_type         head,
   output logic               pop,
   input  back_cfg_type       cfg,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [REPLY_W-1:0] rsp_reply_kind,
   output logic [COUNT_W-1:0] rsp_pulse_value,
   output logic [TIME_W-1:0]  rsp_elapsed_ms,
   output logic               rsp_piston_drive
);

   typedef enum logic [1:0] {
      ST_INACTIVE,
      ST_ACTIVE,
      ST_DONE
   } status_type;

   localparam logic [REPLY_W-1:0] REPLY_EXTENDED  = 3'd0;
   localparam logic [REPLY_W-1:0] REPLY_RETRACTED = 3'd1;
   localparam logic [REPLY_W-1:0] REPLY_COUNT     = 3'd2;
   localparam logic [REPLY_W-1:0] REPLY_MEASURE   = 3'd3;
   localparam logic [REPLY_W-1:0] REPLY_PENDING   = 3'd4;

   logic [COUNT_W-1:0] pulse_count_ff, pulse_count_in;
   logic               moved_ff, moved_in;
   status_type         adv_status_ff, adv_status_in;
   status_type         ret_status_ff, ret_status_in;
   logic [COUNT_W-1:0] adv_pulses_ff, adv_pulses_in;
   logic [COUNT_W-1:0] ret_pulses_ff, ret_pulses_in;
   logic [TIME_W-1:0]  adv_time_ff, adv_time_in;
   logic [TIME_W-1:0]  ret_time_ff, ret_time_in;
   logic [GRACE_W-1:0] grace_ff, grace_in;
   logic               drive_ff, drive_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [REPLY_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [COUNT_W-1:0] rsp_pulses_ff, rsp_pulses_in;
   logic [TIME_W-1:0]  rsp_time_ff, rsp_time_in;
   logic               rsp_drive_ff, rsp_drive_in;

   logic               is_reply;
   logic               can_reply;
   logic               execute;
   logic               sel_adv;
   logic               sel_ret;
   logic [TIME_W-1:0]  cur_time;
   logic [TIME_W-1:0]  new_time;
   logic               finish;
   logic [COUNT_W:0]   pulse_next;

   assign is_reply  = (head.op != OP_PULSE) && (head.op != OP_TICK);
   assign can_reply = !rsp_valid_ff || !rsp_stall;
   assign execute   = head.valid && (!is_reply || can_reply);
   assign pop       = execute;

   // Advance takes precedence if both measurements are active.
   assign sel_adv  = (adv_status_ff == ST_ACTIVE);
   assign sel_ret  = !sel_adv && (ret_status_ff == ST_ACTIVE);
   assign cur_time = sel_adv ? adv_time_ff : ret_time_ff;
   assign pulse_next = {1'b0, pulse_count_ff} + 1'b1;

   // Stall detection for the tick: time counts only outside the grace wait.
   always_comb begin
      new_time = cur_time;
      finish   = 1'b0;
      grace_in = grace_ff;
      moved_in = moved_ff;
      if (grace_ff == '0) begin
         new_time = (cur_time == '1) ? cur_time : cur_time + 1'b1;
         if (moved_ff) begin
            moved_in = 1'b0;
         end else begin
            grace_in = cfg.grace_ticks;
            finish   = (cfg.grace_ticks == '0);
         end
      end else begin
         grace_in = grace_ff - 1'b1;
         if (grace_ff == GRACE_W'(1)) begin
            if (moved_ff) begin
               moved_in = 1'b0;
            end else begin
               finish = 1'b1;
            end
         end
      end
   end

   always_comb begin
      pulse_count_in = pulse_count_ff;
      adv_status_in  = adv_status_ff;
      ret_status_in  = ret_status_ff;
      adv_pulses_in  = adv_pulses_ff;
      ret_pulses_in  = ret_pulses_ff;
      adv_time_in    = adv_time_ff;
      ret_time_in    = ret_time_ff;
      drive_in       = drive_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_pulses_in  = '0;
      rsp_time_in    = '0;

      case (head.op)
         OP_PULSE: begin
            pulse_count_in = (pulse_next > {1'b0, cfg.wrap_limit}) ? '0
                                                                   : pulse_next[COUNT_W-1:0];
         end
         OP_TICK: begin
            if (sel_adv) begin
               adv_time_in = new_time;
               if (finish) begin
                  adv_status_in = ST_DONE;
                  adv_pulses_in = pulse_count_ff;
               end
            end else if (sel_ret) begin
               ret_time_in = new_time;
               if (finish) begin
                  ret_status_in = ST_DONE;
                  ret_pulses_in = pulse_count_ff;
               end
            end
         end
         OP_EXTEND: begin
            drive_in       = 1'b1;
            pulse_count_in = '0;
            rsp_kind_in    = REPLY_EXTENDED;
         end
         OP_RETRACT: begin
            drive_in       = 1'b0;
            pulse_count_in = '0;
            rsp_kind_in    = REPLY_RETRACTED;
         end
         OP_ZERO: begin
            pulse_count_in = '0;
            rsp_kind_in    = REPLY_COUNT;
         end
         OP_READ: begin
            rsp_pulses_in  = pulse_count_ff;
            pulse_count_in = '0;
            rsp_kind_in    = REPLY_COUNT;
         end
         OP_MEASURE_ADVANCE: begin
            drive_in       = 1'b1;
            pulse_count_in = '0;
            adv_status_in  = ST_ACTIVE;
            ret_status_in  = ST_INACTIVE;
            adv_pulses_in  = '0;
            adv_time_in    = '0;
            rsp_kind_in    = REPLY_EXTENDED;
         end
         OP_MEASURE_RETRACT: begin
            drive_in       = 1'b0;
            pulse_count_in = '0;
            ret_status_in  = ST_ACTIVE;
            adv_status_in  = ST_INACTIVE;
            ret_pulses_in  = '0;
            ret_time_in    = '0;
            rsp_kind_in    = REPLY_RETRACTED;
         end
         OP_RESET: begin
            drive_in       = 1'b0;
            pulse_count_in = '0;
            adv_status_in  = ST_INACTIVE;
            ret_status_in  = ST_INACTIVE;
            adv_pulses_in  = '0;
            ret_pulses_in  = '0;
            adv_time_in    = '0;
            ret_time_in    = '0;
            rsp_kind_in    = REPLY_RETRACTED;
         end
         default: begin
            if (adv_status_ff == ST_DONE) begin
               rsp_kind_in   = REPLY_MEASURE;
               rsp_pulses_in = adv_pulses_ff;
               rsp_time_in   = adv_time_ff;
            end else if (ret_status_ff == ST_DONE) begin
               rsp_kind_in   = REPLY_MEASURE;
               rsp_pulses_in = ret_pulses_ff;
               rsp_time_in   = ret_time_ff;
            end else begin
               rsp_kind_in   = REPLY_PENDING;
            end
         end
      endcase
      rsp_drive_in = drive_in;
   end

   assign rsp_valid_in = (execute && is_reply) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_count_ff <= '0;
         moved_ff       <= 1'b1;
         adv_status_ff  <= ST_INACTIVE;
         ret_status_ff  <= ST_INACTIVE;
         adv_pulses_ff  <= '0;
         ret_pulses_ff  <= '0;
         adv_time_ff    <= '0;
         ret_time_ff    <= '0;
         grace_ff       <= '0;
         drive_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (execute) begin
            pulse_count_ff <= pulse_count_in;
            adv_status_ff  <= adv_status_in;
            ret_status_ff  <= ret_status_in;
            adv_pulses_ff  <= adv_pulses_in;
            ret_pulses_ff  <= ret_pulses_in;
            adv_time_ff    <= adv_time_in;
            ret_time_ff    <= ret_time_in;
            drive_ff       <= drive_in;
            case (head.op)
               OP_PULSE: begin
                  moved_ff <= 1'b1;
               end
               OP_TICK: begin
                  if (sel_adv || sel_ret) begin
                     moved_ff <= moved_in;
                     grace_ff <= grace_in;
                  end
               end
               OP_MEASURE_ADVANCE, OP_MEASURE_RETRACT, OP_RESET: begin
                  moved_ff <= 1'b1;
                  grace_ff <= '0;
               end
               default: begin
                  moved_ff <= moved_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (execute && is_reply) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_pulses_ff <= rsp_pulses_in;
         rsp_time_ff   <= rsp_time_in;
         rsp_drive_ff  <= rsp_drive_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reply_kind   = rsp_kind_ff;
   assign rsp_pulse_value  = rsp_pulses_ff;
   assign rsp_elapsed_ms   = rsp_time_ff;
   assign rsp_piston_drive = rsp_drive_ff;

   a_one_measurement: assert property (@(posedge clock) disable iff (reset)
      !(adv_status_ff == ST_ACTIVE && ret_status_ff == ST_ACTIVE))
      else $error("advance and retract measurements active together");

   a_grace_needs_measure: assert property (@(posedge clock) disable iff (reset)
      grace_ff != '0 |-> (adv_status_ff == ST_ACTIVE || ret_status_ff == ST_ACTIVE))
      else $error("grace wait running with no active measurement");

   a_reply_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(execute && is_reply))
      else $error("held response overwritten by a new reply");

endmodule

>>> sv/piston_stroke_measurer.sv
// Piston stroke measurer.
// The request channel (req_valid, req_stall, req_kind, req_address_byte,
// req_command_code) carries encoder pulses, 1 ms ticks and two-byte commands.
// A request is taken at a rising edge with req_valid high and req_stall low.
// Only commands whose address byte matches the device address produce a
// response on the rsp_ channel; pulses, ticks and foreign commands are silent.
// The csr_ port writes device address, grace length and wrap limit; it is
// always ready and should only be written while the block is idle.
// A request is classified into the queue, and the executor then updates state
// and loads the response register. Throughput is one request per cycle while
// no held response blocks a command at the queue head, set by the executor,
// which retires one queued operation per cycle.
// When rsp_stall holds a response, pulses and ticks still execute; the next
// command waits at the queue head, and req_stall rises once the queue is full.
// Synchronous reset clears the queue, the response valid flag and all measuring
// state, and restores the register reset values; no clearing pass is needed.
module piston_stroke_measurer import psm_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [ADDR_W-1:0]      req_address_byte,
   input  logic [CODE_W-1:0]      req_command_code,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [REPLY_W-1:0]     rsp_reply_kind,
   output logic [COUNT_W-1:0]     rsp_pulse_value,
   output logic [TIME_W-1:0]      rsp_elapsed_ms,
   output logic                   rsp_piston_drive,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers. Writes to an unused index are dropped.
   logic [ADDR_W-1:0]  device_address_ff;
   logic [GRACE_W-1:0] grace_ticks_ff;
   logic [COUNT_W-1:0] wrap_limit_ff;

   logic         queue_full;
   op_req_type   push;
   op_req_type   head;
   logic         pop;
   back_cfg_type back_cfg;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEVICE_ADDRESS_RESET;
         grace_ticks_ff    <= STALL_GRACE_RESET;
         wrap_limit_ff     <= WRAP_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: device_address_ff <= csr_wdata[ADDR_W-1:0];
            CSR_STALL_GRACE:    grace_ticks_ff    <= csr_wdata[GRACE_W-1:0];
            CSR_WRAP_LIMIT:     wrap_limit_ff     <= csr_wdata[COUNT_W-1:0];
            default:            device_address_ff <= device_address_ff;
         endcase
      end
   end

   assign back_cfg.grace_ticks = grace_ticks_ff;
   assign back_cfg.wrap_limit  = wrap_limit_ff;

   // Front end: classifies each request and drops the ones that do nothing.
   psm_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_address_byte (req_address_byte),
      .req_command_code (req_command_code),
      .device_address   (device_address_ff),
      .queue_full       (queue_full),
      .push             (push)
   );

   // Short queue that decouples classification from execution.
   psm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // Back end: holds the piston and measurement state and the response register.
   psm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .cfg              (back_cfg),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_reply_kind   (rsp_reply_kind),
      .rsp_pulse_value  (rsp_pulse_value),
      .rsp_elapsed_ms   (rsp_elapsed_ms),
      .rsp_piston_drive (rsp_piston_drive)
   );

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import psm_pkg::*;

   // Request kinds carried on req_kind.
   localparam logic [KIND_W-1:0] KIND_PULSE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMMAND = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

   // Command codes. Every code outside one to seven is a result query.
   localparam logic [CODE_W-1:0] CMD_QUERY           = 8'd0;
   localparam logic [CODE_W-1:0] CMD_EXTEND          = 8'd1;
   localparam logic [CODE_W-1:0] CMD_RETRACT         = 8'd2;
   localparam logic [CODE_W-1:0] CMD_ZERO            = 8'd3;
   localparam logic [CODE_W-1:0] CMD_READ            = 8'd4;
   localparam logic [CODE_W-1:0] CMD_MEASURE_ADVANCE = 8'd5;
   localparam logic [CODE_W-1:0] CMD_MEASURE_RETRACT = 8'd6;
   localparam logic [CODE_W-1:0] CMD_RESET           = 8'd7;
   localparam logic [CODE_W-1:0] CMD_QUERY_TOP       = 8'd255;

   // Reply kinds on rsp_reply_kind.
   localparam logic [REPLY_W-1:0] REPLY_EXTENDED    = 3'd0;
   localparam logic [REPLY_W-1:0] REPLY_RETRACTED   = 3'd1;
   localparam logic [REPLY_W-1:0] REPLY_COUNT       = 3'd2;
   localparam logic [REPLY_W-1:0] REPLY_MEASUREMENT = 3'd3;
   localparam logic [REPLY_W-1:0] REPLY_PENDING     = 3'd4;

   localparam logic [TIME_W-1:0] TIME_CEILING = '1;

   localparam int STROKE_ADVANCE = 0;
   localparam int STROKE_RETRACT = 1;

   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 240;
   localparam int TAIL_CYCLES = 4;
   localparam int DRAIN_LIMIT = 20000;

   typedef enum logic [1:0] {
      STROKE_IDLE,
      STROKE_RUNNING,
      STROKE_DONE
   } stroke_state_type;

   typedef struct packed {
      logic [REPLY_W-1:0] reply_kind;
      logic [COUNT_W-1:0] pulse_value;
      logic [TIME_W-1:0]  elapsed_ms;
      logic               piston_drive;
   } reply_type;

   // Tracks the piston, the pulse count and the two stroke measurements, and
   // keeps the replies that the accepted commands still owe, oldest first.
   class stroke_reply_board;
      logic [ADDR_W-1:0]  dev_addr;
      logic [GRACE_W-1:0] grace_len;
      logic [COUNT_W-1:0] wrap_limit;
      logic [COUNT_W-1:0] pulse_count;
      logic               moved;
      logic [GRACE_W-1:0] grace_left;
      logic               drive_level;
      stroke_state_type   stroke_status [2];
      logic [COUNT_W-1:0] stroke_pulses [2];
      logic [TIME_W-1:0]  stroke_time [2];
      reply_type          replies_due [$];
      int                 requests_seen;
      int                 replies_seen;
      int                 strokes_reported;
      int                 errors;

      function new();
         dev_addr = DEVICE_ADDRESS_RESET;
         grace_len = STALL_GRACE_RESET;
         wrap_limit = WRAP_LIMIT_RESET;
         clear_motion();
         requests_seen = 0;
         replies_seen = 0;
         strokes_reported = 0;
         errors = 0;
      endfunction

      // The state after reset, which the reset command restores as well.
      function void clear_motion();
         pulse_count = '0;
         moved = 1'b1;
         grace_left = '0;
         drive_level = 1'b0;
         for (int s = 0; s < 2; s++) begin
            stroke_status[s] = STROKE_IDLE;
            stroke_pulses[s] = '0;
            stroke_time[s] = '0;
         end
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_DEVICE_ADDRESS: dev_addr = value[ADDR_W-1:0];
            CSR_STALL_GRACE:    grace_len = value[GRACE_W-1:0];
            CSR_WRAP_LIMIT:     wrap_limit = value[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function void start_stroke(int s);
         pulse_count = '0;
         moved = 1'b1;
         grace_left = '0;
         stroke_status[s] = STROKE_RUNNING;
         stroke_status[1 - s] = STROKE_IDLE;
         stroke_pulses[s] = '0;
         stroke_time[s] = '0;
      endfunction

      // One tick of a running stroke. The time stands still while the grace
      // wait counts down; a stroke ends when the wait runs out with no pulse.
      function void tick_stroke(int s);
         if (grace_left == 0) begin
            if (stroke_time[s] != TIME_CEILING) stroke_time[s] = stroke_time[s] + 1'b1;
            if (moved) begin
               moved = 1'b0;
               return;
            end
            grace_left = grace_len;
            if (grace_left != 0) return;
         end else begin
            grace_left = grace_left - 1'b1;
            if (grace_left != 0) return;
         end
         if (moved) begin
            moved = 1'b0;
         end else begin
            stroke_status[s] = STROKE_DONE;
            stroke_pulses[s] = pulse_count;
         end
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                 logic [CODE_W-1:0] code);
         logic [COUNT_W:0] next_count;
         reply_type        due;
         requests_seen++;
         case (kind)
            KIND_PULSE: begin
               next_count = {1'b0, pulse_count} + 1'b1;
               pulse_count = (next_count > {1'b0, wrap_limit}) ? '0 : next_count[COUNT_W-1:0];
               moved = 1'b1;
            end
            KIND_TICK: begin
               if (stroke_status[STROKE_ADVANCE] == STROKE_RUNNING)
                  tick_stroke(STROKE_ADVANCE);
               else if (stroke_status[STROKE_RETRACT] == STROKE_RUNNING)
                  tick_stroke(STROKE_RETRACT);
            end
            KIND_COMMAND: begin
               if (addr == dev_addr) begin
                  due = '0;
                  case (code)
                     CMD_EXTEND: begin
                        drive_level = 1'b1;
                        pulse_count = '0;
                        due.reply_kind = REPLY_EXTENDED;
                     end
                     CMD_RETRACT: begin
                        drive_level = 1'b0;
                        pulse_count = '0;
                        due.reply_kind = REPLY_RETRACTED;
                     end
                     CMD_ZERO: begin
                        pulse_count = '0;
                        due.reply_kind = REPLY_COUNT;
                     end
                     CMD_READ: begin
                        due.reply_kind = REPLY_COUNT;
                        due.pulse_value = pulse_count;
                        pulse_count = '0;
                     end
                     CMD_MEASURE_ADVANCE: begin
                        start_stroke(STROKE_ADVANCE);
                        drive_level = 1'b1;
                        due.reply_kind = REPLY_EXTENDED;
                     end
                     CMD_MEASURE_RETRACT: begin
                        start_stroke(STROKE_RETRACT);
                        drive_level = 1'b0;
                        due.reply_kind = REPLY_RETRACTED;
                     end
                     CMD_RESET: begin
                        clear_motion();
                        due.reply_kind = REPLY_RETRACTED;
                     end
                     default: begin
                        if (stroke_status[STROKE_ADVANCE] == STROKE_DONE) begin
                           due.reply_kind = REPLY_MEASUREMENT;
                           due.pulse_value = stroke_pulses[STROKE_ADVANCE];
                           due.elapsed_ms = stroke_time[STROKE_ADVANCE];
                        end else if (stroke_status[STROKE_RETRACT] == STROKE_DONE) begin
                           due.reply_kind = REPLY_MEASUREMENT;
                           due.pulse_value = stroke_pulses[STROKE_RETRACT];
                           due.elapsed_ms = stroke_time[STROKE_RETRACT];
                        end else begin
                           due.reply_kind = REPLY_PENDING;
                        end
                     end
                  endcase
                  due.piston_drive = drive_level;
                  replies_due.push_back(due);
               end
            end
            default: ;
         endcase
      endfunction

      function void report_mismatch(string field, logic [COUNT_W-1:0] due_value,
                                    logic [COUNT_W-1:0] got_value);
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, field, due_value, got_value);
      endfunction

      function void check_reply(reply_type got);
         reply_type due;
         replies_seen++;
         if (replies_due.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: reply with none outstanding, expected nothing, got kind %0d",
                        $time, got.reply_kind);
            return;
         end
         due = replies_due.pop_front();
         if (got.reply_kind !== due.reply_kind)
            report_mismatch("reply_kind", COUNT_W'(due.reply_kind), COUNT_W'(got.reply_kind));
         if (got.pulse_value !== due.pulse_value)
            report_mismatch("pulse_value", due.pulse_value, got.pulse_value);
         if (got.elapsed_ms !== due.elapsed_ms)
            report_mismatch("elapsed_ms", COUNT_W'(due.elapsed_ms), COUNT_W'(got.elapsed_ms));
         if (got.piston_drive !== due.piston_drive)
            report_mismatch("piston_drive", COUNT_W'(due.piston_drive),
                            COUNT_W'(got.piston_drive));
         if (got === due && due.reply_kind == REPLY_MEASUREMENT) strokes_reported++;
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      function void flag_leftover();
         if (replies_due.size() != 0) begin
            errors += replies_due.size();
            $display("%0t: %0d replies never arrived, expected them, got none",
                     $time, replies_due.size());
            replies_due.delete();
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [KIND_W-1:0]      req_kind = '0;
   logic [ADDR_W-1:0]      req_address_byte = '0;
   logic [CODE_W-1:0]      req_command_code = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [REPLY_W-1:0]     rsp_reply_kind;
   logic [COUNT_W-1:0]     rsp_pulse_value;
   logic [TIME_W-1:0]      rsp_elapsed_ms;
   logic                   rsp_piston_drive;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   stroke_reply_board board;
   int items_sent = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   piston_stroke_measurer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_address_byte (req_address_byte),
      .req_command_code (req_command_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_reply_kind   (rsp_reply_kind),
      .rsp_pulse_value  (rsp_pulse_value),
      .rsp_elapsed_ms   (rsp_elapsed_ms),
      .rsp_piston_drive (rsp_piston_drive),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard limit on the run; hitting it means the block hung or lost replies.
   initial begin
      #2000000;
      $display("Run timed out with %0d replies outstanding.", board.pending());
      $display("FAILURE");
      $finish;
   end

   // The receiver holds rsp_stall at random. The draw is made at every falling
   // edge, so a stall can land on any cycle of the block's work.
   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Both channels are sampled at the rising edge, before the block's own
   // updates of that edge take effect. A reply is checked before the request
   // of the same edge is noted; the reply cannot belong to that request since
   // the request must first pass through the queue and the response register.
   always @(posedge clock) begin
      reply_type seen;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_reply_kind, rsp_pulse_value, rsp_elapsed_ms, rsp_piston_drive};
            board.check_reply(seen);
         end
         if (req_valid && !req_stall)
            board.note_request(req_kind, req_address_byte, req_command_code);
      end
   end

   // Offers one request, with random idle cycles ahead of it, and returns at
   // the falling edge after it was taken. The valid level is left as it is, so
   // a request that follows right away keeps valid high without a glitch.
   task automatic send_request(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                               logic [CODE_W-1:0] code);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_address_byte <= addr;
      req_command_code <= code;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   // Pulses and ticks ignore the command bytes, so those carry random values.
   task automatic send_event(logic [KIND_W-1:0] kind);
      send_request(kind, ADDR_W'($urandom_range(255)), CODE_W'($urandom_range(255)));
   endtask

   task automatic send_command(logic [CODE_W-1:0] code);
      send_request(KIND_COMMAND, board.dev_addr, code);
   endtask

   // Stops offering requests until every owed reply has arrived, then lets the
   // pipeline settle, since a trailing pulse or tick may still be in flight.
   task automatic wait_until_quiet();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(negedge clock);
      board.flag_leftover();
   endtask

   // Leaves csr_valid high; the caller lowers it once the last write is done.
   task automatic write_register(logic [CSR_INDEX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_register(index, value);
      @(negedge clock);
   endtask

   task automatic configure(logic [ADDR_W-1:0] addr, logic [GRACE_W-1:0] grace,
                            logic [COUNT_W-1:0] limit);
      write_register(CSR_DEVICE_ADDRESS, CSR_DATA_W'(addr));
      write_register(CSR_STALL_GRACE, CSR_DATA_W'(grace));
      write_register(CSR_WRAP_LIMIT, limit);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // A measured stroke as the firmware would run it: arm, move for a few
   // ticks, go quiet long enough for the grace wait to run out most of the
   // time, then ask for the result. Stray pulses in the quiet part restart
   // the stall check.
   task automatic run_stroke();
      int quiet;
      send_command($urandom_range(1) ? CMD_MEASURE_ADVANCE : CMD_MEASURE_RETRACT);
      repeat ($urandom_range(1, 6)) begin
         repeat ($urandom_range(3)) send_event(KIND_PULSE);
         send_event(KIND_TICK);
      end
      quiet = $urandom_range(board.grace_len + 3);
      repeat (quiet) begin
         if ($urandom_range(99) < 8) send_event(KIND_PULSE);
         send_event(KIND_TICK);
      end
      send_command($urandom_range(1) ? CMD_QUERY : CODE_W'($urandom_range(8, 255)));
      if ($urandom_range(3) == 0) send_command(CMD_READ);
   endtask

   initial begin
      int phase;
      int phase_start;
      int pick;
      logic [ADDR_W-1:0] addr;

      board = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The top address, a one-tick grace wait and a wrap
      // limit of two keep the interesting corners within a few requests.
      configure(8'hFF, 8'd1, 30'd2);
      send_command(CMD_QUERY_TOP);                // nothing measured yet
      send_request(KIND_COMMAND, 8'h00, CMD_QUERY); // foreign address, silent
      send_request(KIND_UNUSED, 8'hFF, CMD_EXTEND); // unused kind, ignored
      send_command(CMD_EXTEND);
      repeat (4) send_event(KIND_PULSE);          // third pulse wraps to zero
      send_command(CMD_READ);
      send_command(CMD_ZERO);
      send_event(KIND_TICK);                      // no stroke running
      send_command(CMD_MEASURE_ADVANCE);
      send_event(KIND_PULSE);
      send_event(KIND_TICK);                      // movement seen, time runs
      send_event(KIND_TICK);                      // quiet, grace wait begins
      send_event(KIND_PULSE);
      send_event(KIND_TICK);                      // wait ends, but it moved
      send_event(KIND_TICK);
      send_event(KIND_TICK);                      // stroke finishes here
      send_command(CMD_QUERY);
      send_command(CMD_MEASURE_RETRACT);
      repeat (3) send_event(KIND_TICK);
      send_command(8'd8);                         // lowest query code above reset
      send_command(CMD_RESET);
      wait_until_quiet();

      // Random part. Each phase runs with its own register settings and its
      // own pattern of sender gaps and receiver stalls.
      for (phase = 0; phase < PHASES; phase++) begin
         addr = ADDR_W'($urandom_range(255));
         case (phase)
            0: configure(DEVICE_ADDRESS_RESET, STALL_GRACE_RESET, WRAP_LIMIT_RESET);
            1: configure(8'h00, 8'd1, 30'd1);
            2: configure(8'hFF, 8'd0, 30'd7);
            3: configure(addr, 8'd3, 30'd1000);
            4: configure(addr, 8'd255, 30'd1000000000);
            5: configure(addr, GRACE_W'($urandom_range(1, 20)), COUNT_W'($urandom_range(1, 50)));
            6: configure(addr, GRACE_W'($urandom_range(12)),
                         COUNT_W'($urandom_range(1, 1000000000)));
            default: configure(addr, GRACE_W'($urandom_range(1, 30)),
                               COUNT_W'($urandom_range(1, 300)));
         endcase
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 75;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 75;
            end
            default: begin
               send_idle_pct = 22;
               stall_pct = 22;
            end
         endcase

         // Mostly complete strokes; the rest are lone commands to this device
         // or another one, raw noise of any kind, address and code, and rare drains.
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               run_stroke();
            end else if (pick < 85) begin
               addr = ($urandom_range(7) == 0) ? ADDR_W'($urandom_range(255)) : board.dev_addr;
               if ($urandom_range(4) == 0)
                  send_request(KIND_COMMAND, addr, CODE_W'($urandom_range(255)));
               else
                  send_request(KIND_COMMAND, addr, CODE_W'($urandom_range(7)));
            end else if (pick < 99) begin
               send_request(KIND_W'($urandom_range(3)), ADDR_W'($urandom_range(255)),
                            CODE_W'($urandom_range(255)));
            end else begin
               wait_until_quiet();
            end
         end
         wait_until_quiet();
      end

      $display("Covered %0d requests in %0d register settings; %0d replies checked,",
               board.requests_seen, PHASES + 1, board.replies_seen);
      $display("%0d of them finished stroke measurements.", board.strokes_reported);
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
